/* design/rdm_pkg.sv */
`timescale 1ns / 1ps
package rdm_pkg;
  localparam int MaxVertices = 16;
  localparam int MaxEdges = 64;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int MaxKeptOut = 15;
  localparam logic [19:0] TotalMax = 20'd983025;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_CMP, S_EDGE_RD, S_EDGE_DEL, S_WALK_INIT,
    S_WALK_POP, S_WALK_SCAN, S_WALK_DONE, S_TOTAL, S_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic sort_rd;
    logic sort_cmp;
    logic edge_rd;
    logic edge_del;
    logic walk_init;
    logic walk_pop;
    logic walk_scan;
    logic walk_done;
    logic total;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic sort_step_done;
    logic edges_done;
    logic stack_empty;
    logic scan_done;
  } status_t;
endpackage

/* design/rdm_ctrl.sv */
`timescale 1ns / 1ps
module rdm_ctrl import rdm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last,
  input  status_t st,
  output logic    busy,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:      if (start && last) state_next = S_SORT_RD;
      S_SORT_RD:   state_next = st.sort_done ? S_EDGE_RD : S_SORT_CMP;
      S_SORT_CMP:  if (st.sort_step_done) state_next = S_SORT_RD;
      S_EDGE_RD:   state_next = st.edges_done ? S_TOTAL : S_EDGE_DEL;
      S_EDGE_DEL:  state_next = S_WALK_INIT;
      S_WALK_INIT: state_next = S_WALK_POP;
      S_WALK_POP:  state_next = st.stack_empty ? S_WALK_DONE : S_WALK_SCAN;
      S_WALK_SCAN: if (st.scan_done) state_next = S_WALK_POP;
      S_WALK_DONE: state_next = S_EDGE_RD;
      S_TOTAL:     state_next = S_CLEAR;
      S_CLEAR:     state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_LOAD:      begin busy = 1'b0; cmd.load = start; end
      S_SORT_RD:   cmd.sort_rd = 1'b1;
      S_SORT_CMP:  cmd.sort_cmp = 1'b1;
      S_EDGE_RD:   cmd.edge_rd = 1'b1;
      S_EDGE_DEL:  cmd.edge_del = 1'b1;
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WALK_POP:  cmd.walk_pop = 1'b1;
      S_WALK_SCAN: cmd.walk_scan = 1'b1;
      S_WALK_DONE: cmd.walk_done = 1'b1;
      S_TOTAL:     cmd.total = 1'b1;
      S_CLEAR:     cmd.clear = 1'b1;
      default:     cmd = '0;
    endcase
  end
endmodule

/* design/rdm_dp.sv */
`timescale 1ns / 1ps
module rdm_dp import rdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [4:0]  vertex_count,
  input  logic [3:0]  end_a,
  input  logic [3:0]  end_b,
  input  logic [15:0] edge_cost,
  output status_t     st,
  output logic        strobe,
  output logic [3:0]  kept_a,
  output logic [3:0]  kept_b,
  output logic [15:0] kept_cost,
  output logic [19:0] running_total,
  output logic        is_total,
  output logic        last_out
);
  // The edge table is a memory; each transfer of the sort reads one entry.
  logic [23:0] mem [MaxEdges];
  logic [23:0] rd_data;
  logic        wr_en;
  logic [EW-1:0] wr_addr, rd_addr;
  logic [23:0] wr_data;

  logic [EW:0]   edge_count;
  logic [EW:0]   sort_i;
  logic [EW:0]   sort_j;
  logic [23:0]   key;
  logic [EW:0]   edge_i;
  logic [23:0]   cur;
  logic [MaxVertices-1:0] adj [MaxVertices];
  logic [MaxVertices-1:0] visited;
  logic [VW-1:0] stack [MaxVertices];
  logic [VW:0]   sp;
  logic [VW-1:0] u;
  logic [VW:0]   scan_i;
  logic [19:0]   total_cost;
  logic [3:0]    emitted;
  logic [VW:0]   nv;
  logic [MaxVertices-1:0] full;
  logic          have_key;

  logic          sort_phase_wr;
  logic [EW-1:0] wr_addr_s;
  logic [23:0]   wr_data_s;
  logic          cmp_valid;
  logic          sort_step_done;
  logic          walk_fail;

  always_comb begin
    if (vertex_count == 5'd0) nv = (VW+1)'(1);
    else if (vertex_count > 5'(MaxVertices)) nv = (VW+1)'(MaxVertices);
    else nv = (VW+1)'(vertex_count);
    for (int k = 0; k < MaxVertices; k++) full[k] = (k < nv);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Insertion sort: key at sort_i, j walks down with one read per compare.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = edge_count[EW-1:0];
    wr_data = {end_a, end_b, edge_cost};
    rd_addr = sort_i[EW-1:0];
    priority if (cmd.load) begin
      wr_en = (edge_count < (EW+1)'(MaxEdges));
    end else if (cmd.sort_rd) begin
      rd_addr = sort_i[EW-1:0];
    end else if (cmd.sort_cmp) begin
      rd_addr = sort_j[EW-1:0] - EW'(1);
    end else if (cmd.edge_rd) begin
      rd_addr = edge_i[EW-1:0];
    end
    // Writes during sort are issued by the step logic below.
    if (cmd.sort_cmp && sort_phase_wr) begin
      wr_en = 1'b1;
      wr_addr = wr_addr_s;
      wr_data = wr_data_s;
    end
  end

  // In sort_cmp: key is captured first; then mem[j-1] is compared whenever its read data is valid.
  always_comb begin
    sort_phase_wr = 1'b0;
    wr_addr_s = sort_j[EW-1:0];
    wr_data_s = key;
    sort_step_done = 1'b0;
    if (cmd.sort_cmp && have_key && cmp_valid) begin
      if (sort_j != '0 && rd_data[15:0] < key[15:0]) begin
        sort_phase_wr = 1'b1;
        wr_data_s = rd_data;
      end else begin
        sort_phase_wr = 1'b1;
        wr_data_s = key;
        sort_step_done = 1'b1;
      end
    end else if (cmd.sort_cmp && have_key && sort_j == '0) begin
      sort_phase_wr = 1'b1;
      sort_step_done = 1'b1;
    end
  end

  always_comb begin
    st.sort_done = (sort_i >= edge_count);
    st.sort_step_done = sort_step_done;
    st.edges_done = (edge_i >= edge_count);
    st.stack_empty = (sp == '0);
    st.scan_done = (scan_i >= nv - (VW+1)'(1)) || (scan_i == (VW+1)'(MaxVertices - 1));
  end

  logic [3:0] ca, cb;
  logic       link_ok;
  assign ca = cur[23:20];
  assign cb = cur[19:16];
  assign link_ok = (32'(ca) < MaxVertices) && (32'(cb) < MaxVertices);
  logic [VW-1:0] si;
  assign si = scan_i[VW-1:0];
  assign walk_fail = ((visited & full) != full);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      edge_count <= '0;
      total_cost <= '0;
      emitted <= '0;
      visited <= '0;
      sp <= '0;
      sort_i <= (EW+1)'(1);
      edge_i <= '0;
      have_key <= 1'b0;
      cmp_valid <= 1'b0;
      for (int k = 0; k < MaxVertices; k++) adj[k] <= '0;
    end else begin
      strobe <= cmd.total || (cmd.walk_done && walk_fail && (32'(emitted) < MaxKeptOut));
      if (cmd.load && edge_count < (EW+1)'(MaxEdges)) begin
        edge_count <= edge_count + (EW+1)'(1);
        if (32'(end_a) < MaxVertices && 32'(end_b) < MaxVertices) begin
          adj[end_a[VW-1:0]][end_b[VW-1:0]] <= 1'b1;
          adj[end_b[VW-1:0]][end_a[VW-1:0]] <= 1'b1;
        end
      end
      if (cmd.sort_rd) begin
        have_key <= 1'b0;
        cmp_valid <= 1'b0;
        sort_j <= sort_i;
      end
      if (cmd.sort_cmp) begin
        if (!have_key) begin
          key <= rd_data;
          have_key <= 1'b1;
          cmp_valid <= 1'b1;
        end else if (sort_j == '0) begin
          sort_i <= sort_i + (EW+1)'(1);
        end else if (cmp_valid) begin
          if (rd_data[15:0] < key[15:0]) begin
            sort_j <= sort_j - (EW+1)'(1);
            cmp_valid <= 1'b0;
          end else begin
            sort_i <= sort_i + (EW+1)'(1);
          end
        end else begin
          cmp_valid <= 1'b1;
        end
      end
      if (cmd.edge_rd) begin
        edge_i <= edge_i + (EW+1)'(1);
      end
      if (cmd.edge_del) begin
        cur <= rd_data;
        if (32'(rd_data[23:20]) < MaxVertices && 32'(rd_data[19:16]) < MaxVertices) begin
          adj[rd_data[23:20]][rd_data[19:16]] <= 1'b0;
          adj[rd_data[19:16]][rd_data[23:20]] <= 1'b0;
        end
      end
      if (cmd.walk_init) begin
        visited <= MaxVertices'(1);
        stack[0] <= '0;
        sp <= (VW+1)'(1);
      end
      if (cmd.walk_pop && sp != '0) begin
        u <= stack[sp[VW-1:0] - VW'(1)];
        sp <= sp - (VW+1)'(1);
        scan_i <= '0;
      end
      if (cmd.walk_scan) begin
        if (adj[u][si] && !visited[si] && sp < (VW+1)'(MaxVertices) && scan_i < nv) begin
          visited[si] <= 1'b1;
          stack[sp[VW-1:0]] <= si;
          sp <= sp + (VW+1)'(1);
        end
        scan_i <= scan_i + (VW+1)'(1);
      end
      if (cmd.walk_done && walk_fail) begin
        if (link_ok) begin
          adj[ca][cb] <= 1'b1;
          adj[cb][ca] <= 1'b1;
        end
        total_cost <= (21'(total_cost) + 21'(cur[15:0]) > 21'(TotalMax)) ? TotalMax
                      : total_cost + 20'(cur[15:0]);
        if (32'(emitted) < MaxKeptOut) begin
          emitted <= emitted + 4'd1;
          kept_a <= ca;
          kept_b <= cb;
          kept_cost <= cur[15:0];
          running_total <= (21'(total_cost) + 21'(cur[15:0]) > 21'(TotalMax)) ? TotalMax
                           : total_cost + 20'(cur[15:0]);
          is_total <= 1'b0;
          last_out <= 1'b0;
        end
      end
      if (cmd.total) begin
        kept_a <= '0;
        kept_b <= '0;
        kept_cost <= '0;
        running_total <= total_cost;
        is_total <= 1'b1;
        last_out <= 1'b1;
      end
      if (cmd.clear) begin
        edge_count <= '0;
        total_cost <= '0;
        emitted <= '0;
        visited <= '0;
        sort_i <= (EW+1)'(1);
        edge_i <= '0;
        for (int k = 0; k < MaxVertices; k++) adj[k] <= '0;
      end
    end
  end
endmodule

/* design/reverse_delete_mst_top.sv */
`timescale 1ns / 1ps
// Reverse-delete minimum spanning tree. Edges are taken one per cycle while busy
// is low; an edge with last set starts the run. The run sorts the edges by
// descending cost (insertion sort over the edge memory) and then, for each
// edge, does a depth-first walk. Up to MaxKeptOut kept edges and the final
// total each appear for one cycle with done high; the receiver cannot stall,
// so results must be captured when done is high.
module reverse_delete_mst_top import rdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic [3:0]  end_a,
  input  logic [3:0]  end_b,
  input  logic [15:0] edge_cost,
  input  logic        last,
  output logic        done,
  output logic [3:0]  kept_a,
  output logic [3:0]  kept_b,
  output logic [15:0] kept_cost,
  output logic [19:0] running_total,
  output logic        is_total,
  output logic        last_out
);
  logic [4:0] vertex_count;
  cmd_t       cmd;
  status_t    st;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 5'd16;
    else if (cfg_we) vertex_count <= cfg_data;
  end

  rdm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last(last), .st(st), .busy(busy), .cmd(cmd)
  );

  rdm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .vertex_count(vertex_count),
    .end_a(end_a), .end_b(end_b), .edge_cost(edge_cost), .st(st),
    .strobe(done), .kept_a(kept_a), .kept_b(kept_b), .kept_cost(kept_cost),
    .running_total(running_total), .is_total(is_total), .last_out(last_out)
  );
endmodule

/* tb/reverse_delete_mst_top_tb.sv */
`timescale 1ns / 1ps
module reverse_delete_mst_top_tb;
  import rdm_pkg::*;

  typedef struct {
    logic [3:0]  a;
    logic [3:0]  b;
    logic [15:0] cost;
    logic [19:0] total;
    logic        is_tot;
    logic        fin;
  } kept_t;

  class mst_scoreboard;
    logic [23:0] edges[$];
    logic [4:0]  vcount;
    kept_t       pending[$];
    int          errors;

    function new();
      vcount = 5'd16;
      errors = 0;
    endfunction

    function bit connected(logic [15:0] adj[16], int n);
      logic [15:0] seen;
      int stk[$];
      int u;
      seen = 16'h1;
      stk.push_back(0);
      while (stk.size() > 0) begin
        u = stk.pop_back();
        for (int i = 0; i < n; i++) begin
          if (adj[u][i] && !seen[i]) begin
            seen[i] = 1'b1;
            stk.push_back(i);
          end
        end
      end
      for (int i = 0; i < n; i++) if (!seen[i]) return 0;
      return 1;
    endfunction

    function void note_edge(logic [3:0] a, logic [3:0] b, logic [15:0] c, logic fin);
      logic [15:0] adj[16];
      logic [23:0] sorted[$];
      logic [23:0] e;
      logic [19:0] tot;
      int n, j, kept_cnt;
      kept_t k;
      if (edges.size() < MaxEdges) edges.push_back({a, b, c});
      if (!fin) return;
      n = (vcount < 1) ? 1 : (vcount > MaxVertices) ? MaxVertices : int'(vcount);
      foreach (adj[i]) adj[i] = '0;
      foreach (edges[i]) begin
        adj[edges[i][23:20]][edges[i][19:16]] = 1'b1;
        adj[edges[i][19:16]][edges[i][23:20]] = 1'b1;
      end
      foreach (edges[i]) begin
        j = 0;
        while (j < sorted.size() && sorted[j][15:0] >= edges[i][15:0]) j++;
        sorted.insert(j, edges[i]);
      end
      tot = '0;
      kept_cnt = 0;
      foreach (sorted[i]) begin
        e = sorted[i];
        adj[e[23:20]][e[19:16]] = 1'b0;
        adj[e[19:16]][e[23:20]] = 1'b0;
        if (!connected(adj, n)) begin
          adj[e[23:20]][e[19:16]] = 1'b1;
          adj[e[19:16]][e[23:20]] = 1'b1;
          tot = (tot + e[15:0] > TotalMax) ? TotalMax : tot + e[15:0];
          if (kept_cnt < MaxKeptOut) begin
            k = '{e[23:20], e[19:16], e[15:0], tot, 1'b0, 1'b0};
            pending.push_back(k);
            kept_cnt++;
          end
        end
      end
      k = '{4'd0, 4'd0, 16'd0, tot, 1'b1, 1'b1};
      pending.push_back(k);
      edges.delete();
    endfunction

    function void check(kept_t got);
      kept_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.a !== w.a) begin $error("kept_a exp %0d got %0d", w.a, got.a); errors++; end
      if (got.b !== w.b) begin $error("kept_b exp %0d got %0d", w.b, got.b); errors++; end
      if (got.cost !== w.cost) begin
        $error("kept_cost exp %0d got %0d", w.cost, got.cost); errors++;
      end
      if (got.total !== w.total) begin
        $error("running_total exp %0d got %0d", w.total, got.total); errors++;
      end
      if (got.is_tot !== w.is_tot) begin
        $error("is_total exp %0d got %0d", w.is_tot, got.is_tot); errors++;
      end
      if (got.fin !== w.fin) begin
        $error("last_out exp %0d got %0d", w.fin, got.fin); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic [3:0] end_a = '0;
  logic [3:0] end_b = '0;
  logic [15:0] edge_cost = '0;
  logic last = 1'b0;
  logic done;
  logic [3:0] kept_a, kept_b;
  logic [15:0] kept_cost;
  logic [19:0] running_total;
  logic is_total, last_out;

  mst_scoreboard sb = new();

  reverse_delete_mst_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .end_a(end_a), .end_b(end_b), .edge_cost(edge_cost), .last(last),
    .done(done), .kept_a(kept_a), .kept_b(kept_b), .kept_cost(kept_cost),
    .running_total(running_total), .is_total(is_total), .last_out(last_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    kept_t r;
    if (!rst && done) begin
      r = '{kept_a, kept_b, kept_cost, running_total, is_total, last_out};
      sb.check(r);
    end
  end

  task automatic send_edge(input logic [3:0] a, input logic [3:0] b,
                           input logic [15:0] c, input logic fin);
    start <= 1'b1;
    end_a <= a;
    end_b <= b;
    edge_cost <= c;
    last <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_edge(a, b, c, fin);
    @(negedge clk);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_vertices(input logic [4:0] v);
    start <= 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.vcount = v;
  endtask

  task automatic random_graph(input int n_edges, input int nv, input bit tree_first);
    int k, burst;
    logic [3:0] a, b;
    burst = $urandom_range(1, 6);
    for (k = 0; k < n_edges; k++) begin
      if (tree_first && k > 0 && k < nv) begin
        a = 4'(k);
        b = 4'($urandom_range(0, k - 1));
      end else if ($urandom_range(0, 9) == 0) begin
        a = 4'($urandom);
        b = 4'($urandom);
      end else begin
        a = 4'($urandom_range(0, nv - 1));
        b = 4'($urandom_range(0, nv - 1));
      end
      send_edge(a, b, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) :
                16'($urandom), k == n_edges - 1);
      if (--burst == 0) begin
        pause($urandom_range(1, 4));
        burst = $urandom_range(1, 6);
      end
    end
  endtask

  initial begin
    int sent, nv, ne;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_vertices(5'd4);
    send_edge(4'd0, 4'd1, 16'hFFFF, 1'b0);
    send_edge(4'd1, 4'd2, 16'h0000, 1'b0);
    send_edge(4'd2, 4'd3, 16'd7, 1'b0);
    send_edge(4'd0, 4'd1, 16'd7, 1'b0);
    send_edge(4'd3, 4'd0, 16'd7, 1'b0);
    send_edge(4'd15, 4'd9, 16'd5, 1'b0);
    send_edge(4'd2, 4'd2, 16'd3, 1'b1);
    wait_drained();
    set_vertices(5'd0);
    send_edge(4'd0, 4'd0, 16'd1, 1'b1);
    wait_drained();
    set_vertices(5'd31);
    for (int i = 0; i < 15; i++) send_edge(4'(i + 1), 4'(i), 16'hFFFF, 1'b0);
    send_edge(4'd15, 4'd15, 16'h1234, 1'b1);
    wait_drained();
    set_vertices(5'd16);
    for (int i = 0; i < 69; i++) send_edge(4'($urandom), 4'($urandom), 16'($urandom), i == 68);
    wait_drained();
    sent = 0;
    while (sent < 160) begin
      nv = $urandom_range(1, 16);
      ne = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(nv, nv + 8);
      if (sent % 5 == 0) begin
        set_vertices((nv == 16 && $urandom_range(0, 1)) ? 5'($urandom_range(16, 31)) : 5'(nv));
      end
      random_graph(ne, nv, $urandom_range(0, 4) != 0);
      sent += ne;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end
endmodule
